// File: rtl/bbc_pkg.sv
package bbc_pkg;

  localparam int NUM_BUFFERS = 256;
  localparam int IDX_W       = 8;
  localparam int BLOCK_SHIFT = 9;
  localparam int DEVICE_BITS = 8;
  localparam int BLK_W       = 31;
  localparam int OFF_W       = 40;
  localparam int CNT_W       = IDX_W + 1;

  localparam logic [2:0] ACT_GET       = 3'd0;
  localparam logic [2:0] ACT_FILL_DONE = 3'd1;
  localparam logic [2:0] ACT_RELEASE   = 3'd2;
  localparam logic [2:0] ACT_REL_DIRTY = 3'd3;
  localparam logic [2:0] ACT_WR_START  = 3'd4;
  localparam logic [2:0] ACT_WR_DONE   = 3'd5;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_HIT       = 3'd1;
  localparam logic [2:0] ST_MISS      = 3'd2;
  localparam logic [2:0] ST_BUSY      = 3'd3;
  localparam logic [2:0] ST_NOFREE    = 3'd4;
  localparam logic [2:0] ST_WRITEBACK = 3'd5;
  localparam logic [2:0] ST_IOERR     = 3'd6;

  localparam logic [1:0] CMD_NONE  = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;

  // flag bit positions
  localparam int F_BUSY    = 0;
  localparam int F_DIRTY   = 1;
  localparam int F_DONE    = 2;
  localparam int F_INVALID = 3;

  typedef struct packed {
    logic [DEVICE_BITS-1:0] dev;
    logic [BLK_W-1:0]       blk;
    logic [3:0]             flags;
    logic [IDX_W-1:0]       nx;
    logic [IDX_W-1:0]       pv;
    logic                   on;
  } entry_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
  } rd_req_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    entry_t           data;
  } wr_req_t;

  function automatic logic [OFF_W-1:0] offset_of(input logic [BLK_W-1:0] b);
    offset_of = OFF_W'({b, {BLOCK_SHIFT{1'b0}}});
  endfunction

endpackage

// File: rtl/block_buffer_cache_lru.sv
// Channel  | handshake            | word carried
// ---------+----------------------+---------------------------------------------
// in_      | in_valid / in_stall  | action, device, block_number, buffer_index,
//          |                      | io_error
// out_     | out_valid / out_stall| status, result_buffer, need_fill,
//          |                      | io_command, io_offset
//
// One word is worked on at a time. Get walks the header memory one entry a
// cycle: a hit on entry k ends the walk there and a miss ends it after the
// last entry; an undefined action goes straight to the result. Every list
// neighbour is a read then a write. After reset a clearing pass over every
// entry loads the header memory with in_stall high; a result held by
// out_stall lets the next word in.
module block_buffer_cache_lru
  import bbc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [2:0]             in_action,
  input  logic [7:0]             in_device,
  input  logic [30:0]            in_block_number,
  input  logic [7:0]             in_buffer_index,
  input  logic                   in_io_error,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [2:0]             out_status,
  output logic [7:0]             out_result_buffer,
  output logic                   out_need_fill,
  output logic [1:0]             out_io_command,
  output logic [39:0]            out_io_offset
);

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_SCAN = 4'd2;
  localparam logic [3:0] S_RD   = 4'd3;
  localparam logic [3:0] S_EXEC = 4'd4;
  localparam logic [3:0] S_N0R  = 4'd5;
  localparam logic [3:0] S_N0W  = 4'd6;
  localparam logic [3:0] S_N1R  = 4'd7;
  localparam logic [3:0] S_N1W  = 4'd8;
  localparam logic [3:0] S_WB   = 4'd9;
  localparam logic [3:0] S_OUT  = 4'd10;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BUFFERS - 1);

  logic [3:0]       state_r, state_nxt;
  logic [IDX_W-1:0] clr_r;
  logic [CNT_W-1:0] scan_r;
  logic             chk_v_r;
  logic [IDX_W-1:0] chk_idx_r;

  logic [2:0]             act_r;
  logic [DEVICE_BITS-1:0] dev_r;
  logic [BLK_W-1:0]       blk_r;
  logic                   err_r;
  logic [IDX_W-1:0]       tgt_r;
  logic                   hit_r;

  logic [IDX_W-1:0] head_r, tail_r;
  logic [CNT_W-1:0] cnt_r;

  entry_t           cur_r;
  logic             n0_v_r, n0_nx_r, n1_v_r;
  logic [IDX_W-1:0] n0_a_r, n0_val_r, n1_a_r, n1_val_r;

  logic [2:0]       st_r;
  logic [IDX_W-1:0] rb_r;
  logic             fl_r;
  logic [1:0]       cm_r;
  logic [OFF_W-1:0] of_r;

  logic             out_valid_r;
  logic [2:0]       out_status_r;
  logic [IDX_W-1:0] out_rb_r;
  logic             out_fill_r;
  logic [1:0]       out_cmd_r;
  logic [OFF_W-1:0] out_off_r;

  rd_req_t rd;
  wr_req_t wr;
  entry_t  rq;

  bbc_hdr_ram u_ram (
    .clk     (clk),
    .rd      (rd),
    .wr      (wr),
    .rd_data (rq)
  );

  logic in_acc;
  logic scan_match;
  assign in_stall   = (state_r != S_IDLE);
  assign in_acc     = in_valid && !in_stall;
  assign scan_match = chk_v_r && !rq.flags[F_INVALID] && (rq.blk == blk_r) &&
                      (rq.dev == dev_r);

  // decision on the target header
  entry_t           e;
  logic [2:0]       x_st;
  logic [IDX_W-1:0] x_rb;
  logic             x_fl;
  logic [1:0]       x_cm;
  logic [OFF_W-1:0] x_of;
  logic [IDX_W-1:0] x_hd, x_tl;
  logic [CNT_W-1:0] x_cn;
  logic             x_n0v, x_n0nx, x_n1v;
  logic [IDX_W-1:0] x_n0a, x_n0val, x_n1a, x_n1val;
  logic             do_unlink, do_link;

  always_comb begin
    e       = rq;
    x_st    = ST_OK;
    x_rb    = tgt_r;
    x_fl    = 1'b0;
    x_cm    = CMD_NONE;
    x_of    = '0;
    x_hd    = head_r;
    x_tl    = tail_r;
    x_cn    = cnt_r;
    x_n0v   = 1'b0;
    x_n0nx  = 1'b1;
    x_n0a   = '0;
    x_n0val = '0;
    x_n1v   = 1'b0;
    x_n1a   = '0;
    x_n1val = '0;
    do_unlink = 1'b0;
    do_link   = 1'b0;

    if (act_r == ACT_GET) begin
      if (hit_r) begin
        if (rq.flags[F_BUSY]) begin
          x_st = ST_BUSY;
        end else begin
          do_unlink = 1'b1;
          e.flags[F_BUSY] = 1'b1;
          x_st = ST_HIT;
          if (!rq.flags[F_DONE] && !rq.flags[F_DIRTY]) begin
            x_fl = 1'b1;
            x_cm = CMD_READ;
            x_of = offset_of(rq.blk);
          end else begin
            e.flags[F_DONE] = 1'b1;
          end
        end
      end else begin
        do_unlink = 1'b1;
        if (rq.flags[F_DIRTY]) begin
          e.flags[F_BUSY]  = 1'b1;
          e.flags[F_DIRTY] = 1'b0;
          e.flags[F_DONE]  = 1'b0;
          x_st = ST_WRITEBACK;
          x_cm = CMD_WRITE;
          x_of = offset_of(rq.blk);
        end else begin
          e.flags = 4'b0001;
          e.dev   = dev_r;
          e.blk   = blk_r;
          x_st = ST_MISS;
          x_fl = 1'b1;
          x_cm = CMD_READ;
          x_of = offset_of(blk_r);
        end
      end
    end else if (rq.flags[F_BUSY]) begin
      case (act_r)
        ACT_FILL_DONE: begin
          if (err_r) begin
            x_st = ST_IOERR;
            e.flags[F_BUSY] = 1'b0;
            do_link = 1'b1;
          end else begin
            e.flags[F_DONE]    = 1'b1;
            e.flags[F_INVALID] = 1'b0;
          end
        end
        ACT_RELEASE: begin
          e.flags[F_BUSY] = 1'b0;
          do_link = 1'b1;
        end
        ACT_REL_DIRTY: begin
          e.flags[F_DIRTY] = 1'b1;
          e.flags[F_DONE]  = 1'b0;
          e.flags[F_BUSY]  = 1'b0;
          do_link = 1'b1;
        end
        ACT_WR_START: begin
          e.flags[F_DONE]  = 1'b0;
          e.flags[F_DIRTY] = 1'b0;
          x_cm = CMD_WRITE;
          x_of = offset_of(rq.blk);
        end
        ACT_WR_DONE: begin
          if (err_r) begin
            x_st = ST_IOERR;
          end else begin
            e.flags[F_DONE] = 1'b1;
            e.flags[F_BUSY] = 1'b0;
            do_link = 1'b1;
          end
        end
        default: ;
      endcase
    end

    if (do_unlink && rq.on) begin
      if (tgt_r == head_r) begin
        x_hd = rq.nx;
      end else begin
        x_n0v   = 1'b1;
        x_n0nx  = 1'b1;
        x_n0a   = rq.pv;
        x_n0val = rq.nx;
      end
      if (tgt_r == tail_r) begin
        x_tl = rq.pv;
      end else begin
        x_n1v   = 1'b1;
        x_n1a   = rq.nx;
        x_n1val = rq.pv;
      end
      e.on = 1'b0;
      x_cn = cnt_r - CNT_W'(1);
    end

    if (do_link && !rq.on) begin
      if (cnt_r == '0) begin
        x_hd = tgt_r;
        x_tl = tgt_r;
      end else if (e.flags[F_INVALID]) begin
        x_n0v   = 1'b1;
        x_n0nx  = 1'b0;
        x_n0a   = head_r;
        x_n0val = tgt_r;
        e.nx    = head_r;
        x_hd    = tgt_r;
      end else begin
        x_n0v   = 1'b1;
        x_n0nx  = 1'b1;
        x_n0a   = tail_r;
        x_n0val = tgt_r;
        e.pv    = tail_r;
        x_tl    = tgt_r;
      end
      e.on = 1'b1;
      x_cn = cnt_r + CNT_W'(1);
    end
  end

  // memory requests
  always_comb begin
    rd = '0;
    wr = '0;
    unique case (state_r)
      S_CLR: begin
        wr.en        = 1'b1;
        wr.addr      = clr_r;
        wr.data      = '0;
        wr.data.flags = 4'b1000;
        wr.data.nx   = (clr_r == '0) ? '0 : clr_r - IDX_W'(1);
        wr.data.pv   = (clr_r == LAST_IDX) ? clr_r : clr_r + IDX_W'(1);
        wr.data.on   = 1'b1;
      end
      S_SCAN: begin
        rd.en   = (scan_r < CNT_W'(NUM_BUFFERS));
        rd.addr = scan_r[IDX_W-1:0];
      end
      S_RD: begin
        rd.en   = 1'b1;
        rd.addr = tgt_r;
      end
      S_N0R: begin
        rd.en   = 1'b1;
        rd.addr = n0_a_r;
      end
      S_N0W: begin
        wr.en   = 1'b1;
        wr.addr = n0_a_r;
        wr.data = rq;
        if (n0_nx_r) begin
          wr.data.nx = n0_val_r;
        end else begin
          wr.data.pv = n0_val_r;
        end
      end
      S_N1R: begin
        rd.en   = 1'b1;
        rd.addr = n1_a_r;
      end
      S_N1W: begin
        wr.en      = 1'b1;
        wr.addr    = n1_a_r;
        wr.data    = rq;
        wr.data.pv = n1_val_r;
      end
      S_WB: begin
        wr.en   = 1'b1;
        wr.addr = tgt_r;
        wr.data = cur_r;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLR:  if (clr_r == LAST_IDX) state_nxt = S_IDLE;
      S_IDLE: begin
        if (in_acc) begin
          if (in_action == ACT_GET) begin
            state_nxt = S_SCAN;
          end else if (in_action <= ACT_WR_DONE) begin
            state_nxt = S_RD;
          end else begin
            state_nxt = S_OUT;
          end
        end
      end
      S_SCAN: begin
        if (scan_match) begin
          state_nxt = S_RD;
        end else if (chk_v_r && chk_idx_r == LAST_IDX) begin
          state_nxt = (cnt_r == '0) ? S_OUT : S_RD;
        end
      end
      S_RD:   state_nxt = S_EXEC;
      S_EXEC: state_nxt = x_n0v ? S_N0R : (x_n1v ? S_N1R : S_WB);
      S_N0R:  state_nxt = S_N0W;
      S_N0W:  state_nxt = n1_v_r ? S_N1R : S_WB;
      S_N1R:  state_nxt = S_N1W;
      S_N1W:  state_nxt = S_WB;
      S_WB:   state_nxt = S_OUT;
      S_OUT:  if (!out_valid_r || !out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      head_r      <= LAST_IDX;
      tail_r      <= '0;
      cnt_r       <= CNT_W'(NUM_BUFFERS);
      out_valid_r <= 1'b0;
      chk_v_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLR) begin
        clr_r <= clr_r + IDX_W'(1);
      end

      // walk the tags: read one entry a cycle, compare the one read before
      if (state_r == S_SCAN) begin
        chk_v_r   <= (scan_r < CNT_W'(NUM_BUFFERS));
        chk_idx_r <= scan_r[IDX_W-1:0];
        scan_r    <= scan_r + CNT_W'(1);
        if (scan_match) begin
          tgt_r <= chk_idx_r;
          hit_r <= 1'b1;
        end else if (chk_v_r && chk_idx_r == LAST_IDX) begin
          hit_r <= 1'b0;
          tgt_r <= head_r;
          st_r  <= ST_NOFREE;
          rb_r  <= '0;
          fl_r  <= 1'b0;
          cm_r  <= CMD_NONE;
          of_r  <= '0;
        end
      end else begin
        chk_v_r <= 1'b0;
        scan_r  <= '0;
      end

      if (in_acc) begin
        act_r <= in_action;
        dev_r <= in_device;
        blk_r <= in_block_number;
        err_r <= in_io_error;
        tgt_r <= in_buffer_index;
        // undefined actions answer with an all-zero word
        st_r  <= ST_OK;
        rb_r  <= '0;
        fl_r  <= 1'b0;
        cm_r  <= CMD_NONE;
        of_r  <= '0;
      end

      if (state_r == S_EXEC) begin
        cur_r    <= e;
        head_r   <= x_hd;
        tail_r   <= x_tl;
        cnt_r    <= x_cn;
        n0_v_r   <= x_n0v;
        n0_nx_r  <= x_n0nx;
        n0_a_r   <= x_n0a;
        n0_val_r <= x_n0val;
        n1_v_r   <= x_n1v;
        n1_a_r   <= x_n1a;
        n1_val_r <= x_n1val;
        st_r     <= x_st;
        rb_r     <= x_rb;
        fl_r     <= x_fl;
        cm_r     <= x_cm;
        of_r     <= x_of;
      end

      // hold the result until taken, then load the next one
      if (state_r == S_OUT && (!out_valid_r || !out_stall)) begin
        out_valid_r  <= 1'b1;
        out_status_r <= st_r;
        out_rb_r     <= rb_r;
        out_fill_r   <= fl_r;
        out_cmd_r    <= cm_r;
        out_off_r    <= of_r;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_result_buffer = out_rb_r;
  assign out_need_fill     = out_fill_r;
  assign out_io_command    = out_cmd_r;
  assign out_io_offset     = out_off_r;

endmodule

// File: rtl/bbc_hdr_ram.sv
module bbc_hdr_ram
  import bbc_pkg::*;
(
  input  logic    clk,
  input  rd_req_t rd,
  input  wr_req_t wr,
  output entry_t  rd_data
);

  entry_t mem [NUM_BUFFERS];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data_r <= mem[rd.addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
